@@ sv/tdpws_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tdpws_pkg
// Shared types and constants for the tick-driven pot wiper stepper.
// ============================================================================
package tdpws_pkg;

    localparam int unsigned POS_W   = 7;
    localparam int unsigned TIMER_W = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [POS_W-1:0]   FULL_SCALE = 7'd100;
    localparam logic [POS_W-1:0]   POS_ZERO   = 7'd0;
    localparam logic [TIMER_W-1:0] TIMER_MAX  = 16'hFFFF;

    // item opcodes
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_SET_GOAL = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INC_PERIOD       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_PERIOD   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STORE_ON_RELEASE = 2'd3;

    typedef enum logic [2:0] {
        PH_UNSEL = 3'b001,
        PH_SEL   = 3'b010,
        PH_REL   = 3'b100
    } t_phase;

    typedef struct packed {
        logic             op;
        logic [POS_W-1:0] goal_value;
        logic             lock_offered;
    } t_in_item;

    typedef struct packed {
        logic             chip_select_n;
        logic             direction_pin;
        logic             increment_pin;
        logic             lock_held;
        logic [POS_W-1:0] wiper_position;
        logic             at_goal;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [TIMER_W-1:0]   value;
    } t_cfg_write;

    typedef struct packed {
        logic               invert_direction;
        logic [TIMER_W-1:0] inc_period_ticks;
        logic [TIMER_W-1:0] release_period_ticks;
        logic               store_on_release;
    } t_cfg;

    typedef struct packed {
        t_phase             phase;
        logic [POS_W-1:0]   goal;
        logic [POS_W-1:0]   cur;
        logic               inc_level;
        logic               dir_level;
        logic               cs_level;
        logic               lock_owned;
        logic [TIMER_W-1:0] inc_elapsed;
        logic [TIMER_W-1:0] rel_elapsed;
    } t_state;

endpackage

@@ sv/tdpws_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tdpws channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ============================================================================
interface tdpws_in_if;
    logic                valid;
    logic                ready;
    tdpws_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tdpws_out_if;
    logic                 valid;
    logic                 ready;
    tdpws_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tdpws_cfg_if;
    logic                  valid;
    logic                  ready;
    tdpws_pkg::t_cfg_write data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/tick_driven_pot_wiper_stepper.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tick_driven_pot_wiper_stepper
// Controller for an up/down/increment digital potentiometer. Each input item
// is either one tick of time or a new goal position (0..100, larger values
// saturate). Ticks take the shared chip-select lock when offered, step the
// wiper with INC toggles at the programmed period, and at the goal drive INC
// to the store level, raise CS and keep the lock for the release period.
// Every item yields exactly one result item showing the pin levels, lock
// ownership, assumed wiper position and an at-goal flag after that item.
// Rate: one item per clock. The item updates the state registers in the
// accepting cycle through a single pass of next-state logic (two 16-bit
// increment/compares and a 7-bit step), and its result is held in an output
// register the following cycle; the input stays ready while that register is
// empty or being drained. Register writes are always accepted and should be
// made only while the block is idle.
// ============================================================================
module tick_driven_pot_wiper_stepper (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tdpws_in_if.sink       i_in,
    tdpws_out_if.source    o_out,
    tdpws_cfg_if.sink      i_cfg
);

    tdpws_pkg::t_state    r_state;
    tdpws_pkg::t_state    n_state;
    tdpws_pkg::t_cfg      r_cfg;
    tdpws_pkg::t_out_item r_out;
    logic                 r_out_valid;
    logic                 w_in_acc;

    // input flows whenever the result register is free or draining
    assign i_in.ready  = ~r_out_valid | o_out.ready;
    assign w_in_acc    = i_in.valid & i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    tdpws_step u_step (
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .i_item  (i_in.data),
        .o_next  (n_state)
    );

    // state registers: reset values match a freshly powered controller
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase       <= tdpws_pkg::PH_UNSEL;
            r_state.goal        <= tdpws_pkg::POS_ZERO;
            r_state.cur         <= tdpws_pkg::POS_ZERO;
            r_state.inc_level   <= 1'b0;
            r_state.dir_level   <= 1'b1;
            r_state.cs_level    <= 1'b1;
            r_state.lock_owned  <= 1'b0;
            r_state.inc_elapsed <= tdpws_pkg::TIMER_MAX;
            r_state.rel_elapsed <= tdpws_pkg::TIMER_MAX;
        end else if (w_in_acc) begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.invert_direction     <= 1'b0;
            r_cfg.inc_period_ticks     <= 16'd1;
            r_cfg.release_period_ticks <= 16'd20;
            r_cfg.store_on_release     <= 1'b0;
        end else if (i_cfg.valid & i_cfg.ready) begin
            case (i_cfg.data.index)
                tdpws_pkg::REG_INVERT_DIRECTION: begin
                    r_cfg.invert_direction <= i_cfg.data.value[0];
                end
                tdpws_pkg::REG_INC_PERIOD: begin
                    r_cfg.inc_period_ticks <= i_cfg.data.value;
                end
                tdpws_pkg::REG_RELEASE_PERIOD: begin
                    r_cfg.release_period_ticks <= i_cfg.data.value;
                end
                tdpws_pkg::REG_STORE_ON_RELEASE: begin
                    r_cfg.store_on_release <= i_cfg.data.value[0];
                end
                default: begin
                end
            endcase
        end
    end

    // result register: valid flag under reset, payload loads on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out.chip_select_n  <= n_state.cs_level;
            r_out.direction_pin  <= n_state.dir_level;
            r_out.increment_pin  <= n_state.inc_level;
            r_out.lock_held      <= n_state.lock_owned;
            r_out.wiper_position <= n_state.cur;
            r_out.at_goal        <= (n_state.cur == n_state.goal);
        end
    end

    // lock is owned exactly while selected or releasing
    a_lock_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.lock_owned == (r_state.phase != tdpws_pkg::PH_UNSEL))
        else $error("lock ownership out of step with select phase");

    // chip is selected only in the selected phase
    a_cs_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.cs_level == 1'b0) == (r_state.phase == tdpws_pkg::PH_SEL))
        else $error("chip select level out of step with select phase");

    // position changes only when an item is taken
    a_pos_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> $stable(r_state.cur))
        else $error("wiper position moved without an item");

    // a stalled result keeps its valid flag
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> r_out_valid)
        else $error("pending result dropped");

endmodule

@@ sv/tdpws_step.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tdpws_step
// Next-state logic for one item: a tick of time or a new goal.
// ============================================================================
module tdpws_step (
    input  tdpws_pkg::t_state   i_state,
    input  tdpws_pkg::t_cfg     i_cfg,
    input  tdpws_pkg::t_in_item i_item,
    output tdpws_pkg::t_state   o_next
);

    logic [tdpws_pkg::POS_W-1:0]   goal_sat;
    logic [tdpws_pkg::TIMER_W-1:0] inc_sat;
    logic [tdpws_pkg::TIMER_W-1:0] rel_sat;
    logic                          up;

    always_comb begin
        o_next   = i_state;
        goal_sat = (i_item.goal_value > tdpws_pkg::FULL_SCALE) ?
                   tdpws_pkg::FULL_SCALE : i_item.goal_value;
        inc_sat  = (i_state.inc_elapsed == tdpws_pkg::TIMER_MAX) ?
                   tdpws_pkg::TIMER_MAX : i_state.inc_elapsed + 16'd1;
        rel_sat  = (i_state.rel_elapsed == tdpws_pkg::TIMER_MAX) ?
                   tdpws_pkg::TIMER_MAX : i_state.rel_elapsed + 16'd1;
        up       = i_state.goal > i_state.cur;

        if (i_item.op == tdpws_pkg::OP_SET_GOAL) begin
            if (goal_sat != i_state.goal) begin
                o_next.goal = goal_sat;
                // end-stop goal: assume the far end so a full run resyncs
                if (goal_sat == tdpws_pkg::FULL_SCALE) begin
                    o_next.cur = tdpws_pkg::POS_ZERO;
                end else if (goal_sat == tdpws_pkg::POS_ZERO) begin
                    o_next.cur = tdpws_pkg::FULL_SCALE;
                end
            end
        end else begin
            o_next.inc_elapsed = inc_sat;
            o_next.rel_elapsed = rel_sat;

            if (o_next.phase == tdpws_pkg::PH_REL &&
                rel_sat >= i_cfg.release_period_ticks) begin
                o_next.lock_owned = 1'b0;
                o_next.phase      = tdpws_pkg::PH_UNSEL;
            end

            if (i_state.goal != i_state.cur) begin
                if (o_next.phase == tdpws_pkg::PH_UNSEL && i_item.lock_offered) begin
                    o_next.cs_level   = 1'b0;
                    o_next.lock_owned = 1'b1;
                    o_next.phase      = tdpws_pkg::PH_SEL;
                end
                if (o_next.phase == tdpws_pkg::PH_SEL &&
                    inc_sat >= i_cfg.inc_period_ticks) begin
                    o_next.dir_level   = ~(up ^ i_cfg.invert_direction);
                    o_next.inc_level   = ~i_state.inc_level;
                    o_next.inc_elapsed = '0;
                    // step counted on the falling INC edge
                    if (i_state.inc_level) begin
                        o_next.cur = up ? i_state.cur + 7'd1 : i_state.cur - 7'd1;
                    end
                end
            end else if (o_next.phase == tdpws_pkg::PH_SEL) begin
                o_next.inc_level   = i_cfg.store_on_release;
                o_next.cs_level    = 1'b1;
                o_next.phase       = tdpws_pkg::PH_REL;
                o_next.rel_elapsed = '0;
            end
        end
    end

endmodule

@@ tb/wiper_checker.sv @@
`timescale 1ns / 1ps
// ============================================================================
// wiper_checker
// Watches the item, result and register channels of the pot wiper stepper,
// predicts the pin levels after every accepted item, and compares each
// result with the oldest prediction still waiting.
// ============================================================================
module wiper_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tdpws_in_if   in_ch,
    tdpws_out_if  out_ch,
    tdpws_cfg_if  cfg_ch,
    output int    o_mismatches,
    output int    o_due
);
    import tdpws_pkg::*;

    t_cfg      regs;
    t_state    pot;
    t_out_item pin_levels_due [$];
    int        mismatches = 0;

    function automatic void reset_pot();
        regs.invert_direction     = 1'b0;
        regs.inc_period_ticks     = 16'd1;
        regs.release_period_ticks = 16'd20;
        regs.store_on_release     = 1'b0;
        pot.phase       = PH_UNSEL;
        pot.goal        = POS_ZERO;
        pot.cur         = POS_ZERO;
        pot.inc_level   = 1'b0;
        pot.dir_level   = 1'b1;
        pot.cs_level    = 1'b1;
        pot.lock_owned  = 1'b0;
        pot.inc_elapsed = TIMER_MAX;
        pot.rel_elapsed = TIMER_MAX;
    endfunction

    function automatic void write_register(input t_cfg_write wr);
        case (wr.index)
            REG_INVERT_DIRECTION: regs.invert_direction     = wr.value[0];
            REG_INC_PERIOD:       regs.inc_period_ticks     = wr.value;
            REG_RELEASE_PERIOD:   regs.release_period_ticks = wr.value;
            REG_STORE_ON_RELEASE: regs.store_on_release     = wr.value[0];
            default: ;
        endcase
    endfunction

    // advance the pot state by one item, return the pin levels after it
    function automatic t_out_item next_pin_levels(input t_in_item item);
        logic             up;
        logic [POS_W-1:0] target;
        t_out_item        res;
        if (item.op == OP_SET_GOAL) begin
            target = (item.goal_value > FULL_SCALE) ? FULL_SCALE : item.goal_value;
            // end stop goal: force the opposite end for a full-travel resync
            if (pot.goal != target) begin
                pot.goal = target;
                if (target == FULL_SCALE)
                    pot.cur = POS_ZERO;
                else if (target == POS_ZERO)
                    pot.cur = FULL_SCALE;
            end
        end else begin
            if (pot.inc_elapsed != TIMER_MAX) pot.inc_elapsed = pot.inc_elapsed + 1'b1;
            if (pot.rel_elapsed != TIMER_MAX) pot.rel_elapsed = pot.rel_elapsed + 1'b1;
            if (pot.phase == PH_REL && pot.rel_elapsed >= regs.release_period_ticks) begin
                pot.lock_owned = 1'b0;
                pot.phase      = PH_UNSEL;
            end
            if (pot.goal != pot.cur) begin
                up = pot.goal > pot.cur;
                if (pot.phase != PH_SEL && pot.phase != PH_REL && item.lock_offered) begin
                    pot.cs_level   = 1'b0;
                    pot.lock_owned = 1'b1;
                    pot.phase      = PH_SEL;
                end
                if (pot.phase == PH_SEL && pot.inc_elapsed >= regs.inc_period_ticks) begin
                    pot.dir_level   = ~(up ^ regs.invert_direction);
                    pot.inc_level   = ~pot.inc_level;
                    pot.inc_elapsed = '0;
                    // a step is counted on the falling INC edge
                    if (!pot.inc_level)
                        pot.cur = up ? pot.cur + 1'b1 : pot.cur - 1'b1;
                end
            end else if (pot.phase == PH_SEL) begin
                pot.inc_level   = regs.store_on_release;
                pot.cs_level    = 1'b1;
                pot.phase       = PH_REL;
                pot.rel_elapsed = '0;
            end
        end
        res.chip_select_n  = pot.cs_level;
        res.direction_pin  = pot.dir_level;
        res.increment_pin  = pot.inc_level;
        res.lock_held      = pot.lock_owned;
        res.wiper_position = pot.cur;
        res.at_goal        = (pot.cur == pot.goal);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            reset_pot();
            pin_levels_due.delete();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready)
                write_register(cfg_ch.data);
            // push first so ordering holds even if a result came back at once
            if (in_ch.valid && in_ch.ready)
                pin_levels_due.push_back(next_pin_levels(in_ch.data));
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (pin_levels_due.size() == 0) begin
                    $error("result item with no expectation pending");
                    mismatches++;
                end else begin
                    want = pin_levels_due.pop_front();
                    check_field("chip_select_n", want.chip_select_n, got.chip_select_n);
                    check_field("direction_pin", want.direction_pin, got.direction_pin);
                    check_field("increment_pin", want.increment_pin, got.increment_pin);
                    check_field("lock_held", want.lock_held, got.lock_held);
                    check_field("wiper_position", want.wiper_position, got.wiper_position);
                    check_field("at_goal", want.at_goal, got.at_goal);
                end
            end
        end
        o_mismatches <= mismatches;
        o_due        <= pin_levels_due.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Stimulus and verdict for the tick-driven pot wiper stepper. A short
// directed run hits goal saturation, repeated goals and end-stop resync;
// then phases of random ticks and goal writes under several register
// settings, with random idling on both sides and one long output stall.
// ============================================================================
module tb;
    import tdpws_pkg::*;

    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int QUIET_LIMIT   = 3000;  // cycles with no item moving on any channel
    localparam int SETTLE_CYCLES = 4;     // result register latency plus margin

    logic i_clk;
    logic i_rst_n;

    tdpws_in_if  in_ch ();
    tdpws_out_if out_ch ();
    tdpws_cfg_if cfg_ch ();

    int mismatches;
    int due;

    // shared between the sender and the receiver
    bit idle_en;
    bit hold_req;

    tick_driven_pot_wiper_stepper i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    wiper_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_mismatches (mismatches),
        .o_due        (due)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    function automatic t_in_item make_item(input logic op, input logic [POS_W-1:0] goal,
                                           input logic offered);
        t_in_item it;
        it.op           = op;
        it.goal_value   = goal;
        it.lock_offered = offered;
        return it;
    endfunction

    // mostly ticks with the lock offered, so the wiper keeps travelling;
    // goals lean on the end stops and sometimes overshoot full scale
    function automatic t_in_item random_item();
        t_in_item    it;
        int unsigned pick;
        it.op = ($urandom_range(0, 29) == 0) ? OP_SET_GOAL : OP_TICK;
        pick  = $urandom_range(0, 19);
        if (pick < 3)
            it.goal_value = POS_ZERO;
        else if (pick < 6)
            it.goal_value = FULL_SCALE;
        else if (pick < 8)
            it.goal_value = POS_W'($urandom_range(101, 127));
        else
            it.goal_value = POS_W'($urandom_range(0, 100));
        it.lock_offered = ($urandom_range(0, 6) != 0);
        return it;
    endfunction

    // offer one item and hold it until accepted; valid stays high into
    // the next item unless a gap is taken
    task automatic send_item(input t_in_item it, input bit allow_gap);
        if (allow_gap && idle_en && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // stop offering and wait for every predicted result, then let the
    // result register settle before touching registers; the first edge
    // lets the count pick up an item taken at the edge just passed
    task automatic pause_until_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (due != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // all four registers back to back, valid held high across them
    task automatic set_registers(input bit inv, input int unsigned inc_ticks,
                                 input int unsigned rel_ticks, input bit store);
        t_cfg_write wr [4];
        wr[0].index = REG_INVERT_DIRECTION;
        wr[0].value = {15'd0, inv};
        wr[1].index = REG_INC_PERIOD;
        wr[1].value = inc_ticks[TIMER_W-1:0];
        wr[2].index = REG_RELEASE_PERIOD;
        wr[2].value = rel_ticks[TIMER_W-1:0];
        wr[3].index = REG_STORE_ON_RELEASE;
        wr[3].value = {15'd0, store};
        foreach (wr[k]) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= wr[k];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // one register setting, then n random items; optionally one long
    // output stall with the sender pushing 24 extra items back to back
    task automatic run_phase(input bit inv, input int unsigned inc_ticks,
                             input int unsigned rel_ticks, input bit store,
                             input int n, input bit idle_on, input bit with_hold);
        pause_until_drained();
        set_registers(inv, inc_ticks, rel_ticks, store);
        idle_en = idle_on;
        for (int i = 0; i < n; i++) begin
            if (with_hold && i == n / 3) begin
                hold_req = 1'b1;
                repeat (24) send_item(random_item(), 1'b0);
            end
            send_item(random_item(), 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: random stall bursts, or one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 13)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: ends the run if nothing moves on any channel for too long
    // ------------------------------------------------------------------
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus and verdict
    // ------------------------------------------------------------------
    initial begin
        idle_en  = 1'b1;
        hold_req = 1'b0;
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset-like setting, short INC period
        set_registers(1'b0, 1, 20, 1'b0);
        send_item(make_item(OP_TICK, 7'd5, 1'b1), 1'b1);       // at goal, stays idle
        send_item(make_item(OP_SET_GOAL, 7'd0, 1'b0), 1'b1);   // same goal, no force
        send_item(make_item(OP_SET_GOAL, 7'd127, 1'b1), 1'b1); // saturates, forces 0
        send_item(make_item(OP_TICK, 7'd0, 1'b0), 1'b1);       // lock not offered
        send_item(make_item(OP_TICK, 7'd127, 1'b1), 1'b1);     // select, INC rises
        send_item(make_item(OP_TICK, 7'd0, 1'b1), 1'b1);       // INC falls, step
        send_item(make_item(OP_TICK, 7'd64, 1'b0), 1'b1);
        send_item(make_item(OP_TICK, 7'd1, 1'b1), 1'b1);
        send_item(make_item(OP_SET_GOAL, 7'd100, 1'b0), 1'b1); // same after saturation
        send_item(make_item(OP_SET_GOAL, 7'd0, 1'b1), 1'b1);   // forces full scale
        send_item(make_item(OP_TICK, 7'd3, 1'b1), 1'b1);       // direction flips
        send_item(make_item(OP_TICK, 7'd3, 1'b1), 1'b1);
        send_item(make_item(OP_TICK, 7'd3, 1'b1), 1'b1);
        send_item(make_item(OP_SET_GOAL, 7'd99, 1'b0), 1'b1);  // reached at once
        send_item(make_item(OP_TICK, 7'd0, 1'b0), 1'b1);       // deselect, release
        send_item(make_item(OP_TICK, 7'd0, 1'b1), 1'b1);
        send_item(make_item(OP_SET_GOAL, 7'd1, 1'b1), 1'b1);   // new goal while releasing
        send_item(make_item(OP_TICK, 7'd0, 1'b1), 1'b1);
        send_item(make_item(OP_TICK, 7'd0, 1'b1), 1'b1);
        send_item(make_item(OP_SET_GOAL, 7'd101, 1'b0), 1'b1); // just over full scale
        send_item(make_item(OP_TICK, 7'd0, 1'b1), 1'b1);
        for (int i = 0; i < 40; i++)
            send_item(random_item(), 1'b1);

        // zero periods, store on, plus the long output stall
        run_phase(1'b1, 0, 0, 1'b1, 60, 1'b1, 1'b1);
        run_phase(1'b0, 0, 3, 1'b1, 60, 1'b0, 1'b0);
        run_phase(1'b1, 2, 0, 1'b0, 60, 1'b1, 1'b0);
        // maximum periods: at most one INC toggle, and a lock once taken is kept
        run_phase(1'b0, 65535, 65535, 1'b1, 30, 1'b1, 1'b0);
        run_phase(1'b1, 3, 5, 1'b0, 60, 1'b1, 1'b0);
        run_phase(1'($urandom_range(0, 1)), $urandom_range(0, 4), $urandom_range(0, 30),
                  1'($urandom_range(0, 1)), 60, 1'b1, 1'b0);
        // last stretch runs without idling
        run_phase(1'($urandom_range(0, 1)), $urandom_range(0, 4), $urandom_range(0, 30),
                  1'($urandom_range(0, 1)), 60, 1'b0, 1'b0);

        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && due == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/tdpws_pkg.sv
sv/tdpws_if.sv
sv/tdpws_step.sv
sv/tick_driven_pot_wiper_stepper.sv
tb/wiper_checker.sv
tb/tb.sv
